@@ rtl/core/octs_pkg.sv @@
package octs_pkg;

  // Largest number of divisions per face edge
  localparam int MAX_DIVISIONS = 256;

  localparam int N_W   = 9;   // row / column / divisions
  localparam int M2_W  = 18;  // squared direction component
  localparam int Q_W   = 19;  // squared direction length
  localparam int F_W   = 63;  // 2^62-scaled fraction
  localparam int V_W   = 64;  // radicand
  localparam int RT_W  = 32;  // square root
  localparam int SR_W  = 34;  // square root remainder
  localparam int IDX_W = 16;

  // Fraction: one quotient seed bit, then two bits per stage
  localparam int DIV_STEPS  = 31;
  localparam int SQRT_STEPS = 32;
  // Seed stage, divider stages, root stages, multiplier stage
  localparam int AXIS_LAT = 1 + DIV_STEPS + SQRT_STEPS + 1;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL    = 3'd0,
    CFG_RADIUS   = 3'd1,
    CFG_CENTER_X = 3'd2,
    CFG_CENTER_Y = 3'd3,
    CFG_CENTER_Z = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [8:0] row;
    logic [8:0] col;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        vertex_index;
    logic [1:0]         tri_count;
    logic [15:0]        first_a;
    logic [15:0]        first_b;
    logic [15:0]        first_c;
    logic [15:0]        second_a;
    logic [15:0]        second_b;
    logic [15:0]        second_c;
    logic               bad_input;
  } out_t;

  // Per-item data that rides beside the axis pipelines
  typedef struct packed {
    logic [N_W-1:0] n;
    logic [N_W-1:0] k;
    logic           bad;
    logic           neg_x;
  } side_t;

endpackage

@@ rtl/core/octant_sphere_tessellator_core.sv @@
// Channel  | Signals                                   | Direction
// ---------+-------------------------------------------+----------
// in       | in_valid_i, in_ready_o, in_data_i (row,col) | input
// out      | out_valid_o, out_ready_i, out_data_o       | output
// cfg      | cfg_valid_i, cfg_ready_o, cfg_index_i/data | input
//
// One transaction per cycle sustained while the output does not stall. 68 register
// stages: two setup stages, a 65-stage axis pipeline (divider, root, multiplier)
// and one output stage. The first stage loads at the accept edge unless the
// output is stalled; then the skid register holds the transaction.
// Reset is asynchronous, active low; it clears valids and configuration, but sets radius to 65536.
// A stall at the output freezes the whole pipeline; a one-entry skid register
// takes the transaction offered in that cycle, then in_ready_o drops.
// Configuration writes are always taken (cfg_ready_o is tied high).
module octant_sphere_tessellator_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  octs_pkg::in_t                         in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output octs_pkg::out_t                        out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [octs_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [31:0]                           cfg_data_i
);

  localparam int NW = octs_pkg::N_W;
  localparam int AL = octs_pkg::AXIS_LAT;

  // configuration registers
  logic [7:0]         level_q;
  logic [31:0]        radius_q;
  logic signed [31:0] cx_q, cy_q, cz_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= '0;
      radius_q <= 32'd65536;
      cx_q     <= '0;
      cy_q     <= '0;
      cz_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        octs_pkg::CFG_LEVEL:    level_q  <= cfg_data_i[7:0];
        octs_pkg::CFG_RADIUS:   radius_q <= cfg_data_i;
        octs_pkg::CFG_CENTER_X: cx_q     <= cfg_data_i;
        octs_pkg::CFG_CENTER_Y: cy_q     <= cfg_data_i;
        octs_pkg::CFG_CENTER_Z: cz_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: output empty or being taken
  logic adv;
  logic out_valid_q;
  assign adv = !out_valid_q || out_ready_i;

  // input skid register
  logic          skid_v_q;
  octs_pkg::in_t skid_q;
  logic          src_v;
  octs_pkg::in_t src;

  assign in_ready_o = !skid_v_q;
  assign src_v      = skid_v_q || in_valid_i;
  assign src        = skid_v_q ? skid_q : in_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (adv) begin
      skid_v_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv && in_valid_i && in_ready_o) begin
      skid_q <= in_data_i;
    end
  end

  // stage 1: range check, direction terms
  logic [NW-1:0] d_full, d, n0, k0, mx_d, dz_d;
  logic          bad_d, negx_d;
  logic [NW:0]   k2;

  always_comb begin
    d_full = NW'({1'b0, level_q} + 9'd1);
    d      = (int'(d_full) > octs_pkg::MAX_DIVISIONS) ? NW'(octs_pkg::MAX_DIVISIONS)
                                                      : d_full;
    bad_d  = (src.row > d) || (src.col > src.row);
    // bad positions run a harmless apex point through the math
    n0     = bad_d ? '0 : src.row;
    k0     = bad_d ? '0 : src.col;
    k2     = {k0, 1'b0};
    negx_d = k2 > {1'b0, n0};
    mx_d   = negx_d ? NW'(k2 - {1'b0, n0}) : NW'({1'b0, n0} - k2);
    dz_d   = d - n0;
  end

  logic                 s1_v_q;
  octs_pkg::side_t      s1_sb_q;
  logic [NW-1:0]        s1_mx_q, s1_dz_q;

  // stage 2: squares and squared length
  logic                          s2_v_q;
  octs_pkg::side_t               s2_sb_q;
  logic [octs_pkg::M2_W-1:0]     s2_mx2_q, s2_n2_q, s2_z2_q;
  logic [octs_pkg::Q_W-1:0]      s2_q_q;
  logic [octs_pkg::M2_W-1:0]     mx2, n2, z2;

  // a term can reach 256, so each square needs 17 bits
  always_comb begin
    mx2 = octs_pkg::M2_W'(17'(s1_mx_q) * 17'(s1_mx_q));
    n2  = octs_pkg::M2_W'(17'(s1_sb_q.n) * 17'(s1_sb_q.n));
    z2  = octs_pkg::M2_W'({17'(s1_dz_q) * 17'(s1_dz_q), 1'b0});
  end

  // sideband and valids alongside the axis pipelines
  logic [AL-1:0]   ax_v_q;
  octs_pkg::side_t ax_sb_q [AL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      ax_v_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= src_v;
      s2_v_q      <= s1_v_q;
      ax_v_q      <= {ax_v_q[AL-2:0], s2_v_q};
      out_valid_q <= ax_v_q[AL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sb_q.n     <= n0;
      s1_sb_q.k     <= k0;
      s1_sb_q.bad   <= bad_d;
      s1_sb_q.neg_x <= negx_d;
      s1_mx_q       <= mx_d;
      s1_dz_q       <= dz_d;
      s2_sb_q       <= s1_sb_q;
      s2_mx2_q      <= mx2;
      s2_n2_q       <= n2;
      s2_z2_q       <= z2;
      s2_q_q        <= octs_pkg::Q_W'(mx2) + octs_pkg::Q_W'(n2) + octs_pkg::Q_W'(z2);
      ax_sb_q[0]    <= s2_sb_q;
      for (int i = 1; i < AL; i++) begin
        ax_sb_q[i] <= ax_sb_q[i-1];
      end
    end
  end

  logic [63:0] prod_x, prod_y, prod_z;

  octs_axis u_axis_x (
    .clk_i, .en_i(adv), .m2_i(s2_mx2_q), .q_i(s2_q_q), .radius_i(radius_q),
    .prod_o(prod_x)
  );
  octs_axis u_axis_y (
    .clk_i, .en_i(adv), .m2_i(s2_n2_q), .q_i(s2_q_q), .radius_i(radius_q),
    .prod_o(prod_y)
  );
  octs_axis u_axis_z (
    .clk_i, .en_i(adv), .m2_i(s2_z2_q), .q_i(s2_q_q), .radius_i(radius_q),
    .prod_o(prod_z)
  );

  // round the offset to Q16.16, add to center, saturate
  function automatic logic [31:0] place(input logic signed [31:0] c,
                                        input logic [63:0] p,
                                        input logic neg);
    logic [63:0]        s;
    logic signed [34:0] off, r;
    s   = p + 64'h4000_0000;
    off = $signed({2'b00, s[63:31]});
    r   = neg ? (35'(c) - off) : (35'(c) + off);
    if (r > 35'sd2147483647) begin
      place = 32'h7FFF_FFFF;
    end else if (r < -35'sd2147483648) begin
      place = 32'h8000_0000;
    end else begin
      place = r[31:0];
    end
  endfunction

  octs_pkg::side_t sb;
  octs_pkg::out_t  res;
  logic [16:0]     tn, tm;

  always_comb begin
    sb  = ax_sb_q[AL-1];
    res = '0;
    // triangular numbers for this row and the row above
    tn  = 17'(({8'b0, sb.n} * ({8'b0, sb.n} + 17'd1)) >> 1);
    tm  = tn - 17'(sb.n);
    if (sb.bad) begin
      res.bad_input = 1'b1;
    end else begin
      res.pos_x        = place(cx_q, prod_x, sb.neg_x);
      res.pos_y        = place(cy_q, prod_y, 1'b0);
      res.pos_z        = place(cz_q, prod_z, 1'b0);
      res.vertex_index = 16'(tn + 17'(sb.k));
      if (sb.n != '0 && sb.k == '0) begin
        res.tri_count = 2'd1;
        res.first_a   = 16'(tn);
        res.first_b   = 16'(tn + 17'd1);
        res.first_c   = 16'(tm);
      end else if (sb.n != '0 && sb.k < sb.n) begin
        res.tri_count = 2'd2;
        res.first_a   = 16'(tn + 17'(sb.k));
        res.first_b   = 16'(tm + 17'(sb.k));
        res.first_c   = 16'(tm + 17'(sb.k) - 17'd1);
        res.second_a  = 16'(tn + 17'(sb.k));
        res.second_b  = 16'(tn + 17'(sb.k) + 17'd1);
        res.second_c  = 16'(tm + 17'(sb.k));
      end
    end
  end

  octs_pkg::out_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/octs_axis.sv @@
// One axis: floor(m2*2^62/q), integer square root, times radius.
module octs_axis (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [octs_pkg::M2_W-1:0]   m2_i,
  input  logic [octs_pkg::Q_W-1:0]    q_i,
  input  logic [31:0]                 radius_i,
  output logic [63:0]                 prod_o
);

  localparam int QW = octs_pkg::Q_W;
  localparam int DS = octs_pkg::DIV_STEPS;
  localparam int SS = octs_pkg::SQRT_STEPS;

  logic [octs_pkg::F_W-1:0]  dv_f_q [DS+1];
  logic [QW-1:0]             dv_r_q [DS+1];
  logic [QW-1:0]             dv_d_q [DS+1];

  logic [octs_pkg::V_W-1:0]  sq_v_q    [SS];
  logic [octs_pkg::SR_W-1:0] sq_r_q    [SS];
  logic [octs_pkg::RT_W-1:0] sq_root_q [SS];

  logic [63:0] prod_q;

  // seed: integer part of m2/q is 1 only when m2 == q
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_d_q[0] <= q_i;
      if (QW'(m2_i) == q_i) begin
        dv_f_q[0] <= octs_pkg::F_W'(1);
        dv_r_q[0] <= '0;
      end else begin
        dv_f_q[0] <= '0;
        dv_r_q[0] <= QW'(m2_i);
      end
    end
  end

  for (genvar j = 1; j <= DS; j++) begin : g_div
    logic [QW:0]   t1, t2;
    logic [QW-1:0] r1, r2;
    logic          b1, b2;

    always_comb begin
      t1 = {dv_r_q[j-1], 1'b0};
      b1 = t1 >= {1'b0, dv_d_q[j-1]};
      r1 = b1 ? QW'(t1 - {1'b0, dv_d_q[j-1]}) : t1[QW-1:0];
      t2 = {r1, 1'b0};
      b2 = t2 >= {1'b0, dv_d_q[j-1]};
      r2 = b2 ? QW'(t2 - {1'b0, dv_d_q[j-1]}) : t2[QW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_f_q[j] <= {dv_f_q[j-1][octs_pkg::F_W-3:0], b1, b2};
        dv_r_q[j] <= r2;
        dv_d_q[j] <= dv_d_q[j-1];
      end
    end
  end

  // restoring square root, one result bit per stage
  for (genvar s = 0; s < SS; s++) begin : g_sqrt
    logic [octs_pkg::V_W-1:0]  v;
    logic [octs_pkg::SR_W-1:0] rem;
    logic [octs_pkg::RT_W-1:0] root;
    logic [octs_pkg::SR_W+1:0] cur, trial;
    logic                      ge;

    if (s == 0) begin : g_first
      assign v    = {1'b0, dv_f_q[DS]};
      assign rem  = '0;
      assign root = '0;
    end else begin : g_next
      assign v    = sq_v_q[s-1];
      assign rem  = sq_r_q[s-1];
      assign root = sq_root_q[s-1];
    end

    always_comb begin
      cur   = {rem, v[octs_pkg::V_W-1 -: 2]};
      trial = {2'b00, root, 2'b01};
      ge    = cur >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_v_q[s]    <= {v[octs_pkg::V_W-3:0], 2'b00};
        sq_r_q[s]    <= ge ? octs_pkg::SR_W'(cur - trial) : cur[octs_pkg::SR_W-1:0];
        sq_root_q[s] <= {root[octs_pkg::RT_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 64'(radius_i) * 64'(sq_root_q[SS-1]);
    end
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/core/octs_checker.sv @@
module octs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input octs_pkg::in_t                  in_data_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input octs_pkg::out_t                 out_data_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [octs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [31:0]                    cfg_data_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a flagged position carries nothing else
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_input |->
      out_data_o.pos_x == 0 && out_data_o.vertex_index == 0 &&
      out_data_o.tri_count == 0 && out_data_o.first_a == 0)
    else $error("bad position with nonzero fields");

  // unused triangle slots are zero
  a_tri_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tri_count != 2'd2 |->
      out_data_o.second_a == 0 && out_data_o.second_b == 0 &&
      out_data_o.second_c == 0 && out_data_o.tri_count != 2'd3)
    else $error("bad triangle count or stale second triangle");

  // input backpressure only follows an output stall
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i))
    else $error("input blocked without output stall");

endmodule

bind octant_sphere_tessellator_core octs_checker u_octs_checker (.*);
